// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define VMIC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion that is also checked during reset.
`define VMIC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== design/vmic_pkg.sv =====
// Shared types and constants for the valve mode and interlock controller.
`default_nettype none

package vmic_pkg;

    localparam int DELAY_BITS_DEFAULT = 16;
    localparam int TICKS_W            = 16;
    localparam int CFG_DATA_W         = 16;
    localparam int CFG_INDEX_W        = 3;
    localparam int IN_TDATA_W         = 16;
    localparam int OUT_TDATA_W        = 16;
    localparam int STATUS_W           = 8;

    // Status bits that count as a fault (open fault, close fault, interlock, estop).
    localparam logic [15:0] FAULT_MASK = 16'hFFF0;

    typedef enum logic [1:0] {
        MODE_OUT_OF_SERVICE = 2'd0,
        MODE_LOCAL          = 2'd1,
        MODE_AUTOMATIC      = 2'd2,
        MODE_MANUAL         = 2'd3
    } mode_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SIMULATION_ON         = 3'd0,
        REG_OPEN_CONTACT_USED     = 3'd1,
        REG_CLOSED_CONTACT_USED   = 3'd2,
        REG_INTERLOCK_USED        = 3'd3,
        REG_MUTEX_USED            = 3'd4,
        REG_INTERLOCK_FORCES_OPEN = 3'd5,
        REG_OPEN_FAULT_TICKS      = 3'd6,
        REG_CLOSE_FAULT_TICKS     = 3'd7
    } reg_index_t;

endpackage

`default_nettype wire

// ===== design/valve_mode_interlock_controller.sv =====
// Output: the result of an input transfer is registered and shown on the master side in the next cycle.
// Throughput: one scan tick per clock cycle; the output register frees as it is taken,
// so the slave side stalls only while an untaken result waits and m_tready is low.
// Reset: rst_n clears all latches, fault counters, held outputs and configuration
// registers asynchronously; no clearing pass is needed.
`default_nettype none

module valve_mode_interlock_controller #(
    parameter int DELAY_BITS = vmic_pkg::DELAY_BITS_DEFAULT
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // Scan tick input.
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // [1:0] op_mode, [2] open_command, [3] close_command, [4] reset_command,
    // [5] open_contact, [6] closed_contact, [7] estop_input, [8] stop_request,
    // [9] interlock_request, [10] mutex_request, [11] auto_open_request, [15:12] zero
    input  wire logic [vmic_pkg::IN_TDATA_W-1:0]     s_tdata,
    // Result output.
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // [7:0] status_word, [8] fault_flag, [9] valve_drive, [10] in_service, [15:11] zero
    output logic [vmic_pkg::OUT_TDATA_W-1:0]         m_tdata,
    // Configuration write port.
    input  wire logic                                cfg_we,
    input  wire logic [vmic_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [vmic_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int CMP_W = (DELAY_BITS > vmic_pkg::TICKS_W) ? DELAY_BITS : vmic_pkg::TICKS_W;

    // Configuration registers.
    logic                          simulation_on_reg;
    logic                          open_contact_used_reg;
    logic                          closed_contact_used_reg;
    logic                          interlock_used_reg;
    logic                          mutex_used_reg;
    logic                          interlock_forces_open_reg;
    logic [vmic_pkg::TICKS_W-1:0]  open_fault_ticks_reg;
    logic [vmic_pkg::TICKS_W-1:0]  close_fault_ticks_reg;

    // Controller state.
    logic                          open_state_reg, open_state_next;
    logic                          estop_latch_reg, estop_latch_next;
    logic                          interlock_latch_reg, interlock_latch_next;
    logic                          manual_open_latch_reg, manual_open_latch_next;
    logic [DELAY_BITS-1:0]         open_fault_count_reg, open_fault_count_next;
    logic [DELAY_BITS-1:0]         close_fault_count_reg, close_fault_count_next;
    logic                          held_fault_reg, held_fault_next;
    logic                          held_drive_reg, held_drive_next;

    // Output stage.
    logic                               m_tvalid_reg;
    logic [vmic_pkg::OUT_TDATA_W-1:0]   m_tdata_reg, m_tdata_next;

    // Unpacked input fields.
    vmic_pkg::mode_t  op_mode;
    logic             open_command;
    logic             close_command;
    logic             reset_command;
    logic             open_contact;
    logic             closed_contact;
    logic             estop_input;
    logic             stop_request;
    logic             interlock_request;
    logic             mutex_request;
    logic             auto_open_request;

    logic             in_xfer;

    assign op_mode           = vmic_pkg::mode_t'(s_tdata[1:0]);
    assign open_command      = s_tdata[2];
    assign close_command     = s_tdata[3];
    assign reset_command     = s_tdata[4];
    assign open_contact      = s_tdata[5];
    assign closed_contact    = s_tdata[6];
    assign estop_input       = s_tdata[7];
    assign stop_request      = s_tdata[8];
    assign interlock_request = s_tdata[9];
    assign mutex_request     = s_tdata[10];
    assign auto_open_request = s_tdata[11];

    assign s_tready = !m_tvalid_reg || m_tready;
    assign in_xfer  = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb
    begin
        logic                          ok_open;
        logic                          ok_close;
        logic                          mutex;
        logic                          open_flt;
        logic                          close_flt;
        logic                          block;
        logic                          manual_latch;
        logic [vmic_pkg::STATUS_W-1:0] word;
        logic [vmic_pkg::STATUS_W-1:0] status;
        logic                          fault_out;
        logic                          drive_out;
        logic                          in_service;

        open_state_next        = open_state_reg;
        estop_latch_next       = estop_latch_reg;
        interlock_latch_next   = interlock_latch_reg;
        manual_open_latch_next = manual_open_latch_reg;
        open_fault_count_next  = open_fault_count_reg;
        close_fault_count_next = close_fault_count_reg;
        held_fault_next        = held_fault_reg;
        held_drive_next        = held_drive_reg;

        ok_open      = 1'b0;
        ok_close     = 1'b0;
        mutex        = 1'b0;
        open_flt     = 1'b0;
        close_flt    = 1'b0;
        block        = 1'b0;
        manual_latch = manual_open_latch_reg;
        word         = '0;
        status       = '0;
        fault_out    = held_fault_reg;
        drive_out    = held_drive_reg;
        in_service   = 1'b1;

        case (op_mode)
            vmic_pkg::MODE_OUT_OF_SERVICE:
            begin
                open_state_next      = 1'b0;
                estop_latch_next     = 1'b0;
                interlock_latch_next = 1'b0;
                in_service           = 1'b0;
            end

            vmic_pkg::MODE_LOCAL:
            begin
                open_state_next      = open_contact;
                estop_latch_next     = estop_input;
                interlock_latch_next = 1'b0;
                status = {estop_input, 4'b0000, closed_contact, open_contact, open_contact};
            end

            default:
            begin
                // Expected feedback for the position commanded before this tick.
                if (simulation_on_reg || (!open_contact_used_reg && !closed_contact_used_reg))
                begin
                    ok_open  = open_state_reg;
                    ok_close = !open_state_reg;
                end
                else if (open_contact_used_reg && closed_contact_used_reg)
                begin
                    ok_open  = open_state_reg && open_contact && !closed_contact;
                    ok_close = !open_state_reg && !open_contact && closed_contact;
                end
                else if (open_contact_used_reg)
                begin
                    ok_open  = open_state_reg && open_contact;
                    ok_close = !open_state_reg && !open_contact;
                end
                else
                begin
                    ok_open  = open_state_reg && !closed_contact;
                    ok_close = !open_state_reg && closed_contact;
                end

                if (estop_input || stop_request)
                    estop_latch_next = 1'b1;
                else if (reset_command)
                    estop_latch_next = 1'b0;

                if (!interlock_used_reg)
                    interlock_latch_next = 1'b0;
                else if (interlock_request)
                    interlock_latch_next = 1'b1;
                else if (reset_command)
                    interlock_latch_next = 1'b0;

                mutex = mutex_request && mutex_used_reg;

                // Open fault on-delay: counts up while the mismatch lasts, saturating.
                if (open_state_reg && !ok_open)
                begin
                    if ((CMP_W'(open_fault_count_reg) < CMP_W'(open_fault_ticks_reg)) &&
                        (open_fault_count_reg != '1))
                        open_fault_count_next = open_fault_count_reg + DELAY_BITS'(1);
                    open_flt = CMP_W'(open_fault_count_next) >= CMP_W'(open_fault_ticks_reg);
                end
                else
                begin
                    open_fault_count_next = '0;
                end

                // Close fault on-delay.
                if (!open_state_reg && !ok_close)
                begin
                    if ((CMP_W'(close_fault_count_reg) < CMP_W'(close_fault_ticks_reg)) &&
                        (close_fault_count_reg != '1))
                        close_fault_count_next = close_fault_count_reg + DELAY_BITS'(1);
                    close_flt = CMP_W'(close_fault_count_next) >=
                                CMP_W'(close_fault_ticks_reg);
                end
                else
                begin
                    close_fault_count_next = '0;
                end

                if (op_mode == vmic_pkg::MODE_AUTOMATIC)
                begin
                    if (interlock_forces_open_reg)
                        open_state_next = interlock_latch_next ||
                                          (auto_open_request && !estop_latch_next && !mutex);
                    else
                        open_state_next = auto_open_request && !estop_latch_next &&
                                          !interlock_latch_next && !mutex;
                end
                else
                begin
                    block = estop_latch_next || mutex ||
                            (!interlock_forces_open_reg && interlock_latch_next);
                    if (open_command && !block)
                        manual_latch = 1'b1;
                    if (close_command || block)
                        manual_latch = 1'b0;
                    manual_open_latch_next = manual_latch;
                    open_state_next = manual_latch ||
                                      (interlock_forces_open_reg && interlock_latch_next);
                end

                word = {estop_latch_next, interlock_latch_next, close_flt, open_flt,
                        mutex, closed_contact, open_contact, open_state_next};
                status          = word;
                held_fault_next = |(word & vmic_pkg::FAULT_MASK[vmic_pkg::STATUS_W-1:0]);
                held_drive_next = simulation_on_reg ? 1'b0 : open_state_next;
                fault_out       = held_fault_next;
                drive_out       = held_drive_next;
            end
        endcase

        m_tdata_next = {5'b00000, in_service, drive_out, fault_out, status};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            simulation_on_reg         <= 1'b0;
            open_contact_used_reg     <= 1'b0;
            closed_contact_used_reg   <= 1'b0;
            interlock_used_reg        <= 1'b0;
            mutex_used_reg            <= 1'b0;
            interlock_forces_open_reg <= 1'b0;
            open_fault_ticks_reg      <= '0;
            close_fault_ticks_reg     <= '0;
        end
        else if (cfg_we)
        begin
            case (vmic_pkg::reg_index_t'(cfg_index))
                vmic_pkg::REG_SIMULATION_ON:         simulation_on_reg         <= cfg_data[0];
                vmic_pkg::REG_OPEN_CONTACT_USED:     open_contact_used_reg     <= cfg_data[0];
                vmic_pkg::REG_CLOSED_CONTACT_USED:   closed_contact_used_reg   <= cfg_data[0];
                vmic_pkg::REG_INTERLOCK_USED:        interlock_used_reg        <= cfg_data[0];
                vmic_pkg::REG_MUTEX_USED:            mutex_used_reg            <= cfg_data[0];
                vmic_pkg::REG_INTERLOCK_FORCES_OPEN: interlock_forces_open_reg <= cfg_data[0];
                vmic_pkg::REG_OPEN_FAULT_TICKS:
                    open_fault_ticks_reg  <= cfg_data[vmic_pkg::TICKS_W-1:0];
                vmic_pkg::REG_CLOSE_FAULT_TICKS:
                    close_fault_ticks_reg <= cfg_data[vmic_pkg::TICKS_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_state_reg        <= 1'b0;
            estop_latch_reg       <= 1'b0;
            interlock_latch_reg   <= 1'b0;
            manual_open_latch_reg <= 1'b0;
            open_fault_count_reg  <= '0;
            close_fault_count_reg <= '0;
            held_fault_reg        <= 1'b0;
            held_drive_reg        <= 1'b0;
        end
        else if (in_xfer)
        begin
            open_state_reg        <= open_state_next;
            estop_latch_reg       <= estop_latch_next;
            interlock_latch_reg   <= interlock_latch_next;
            manual_open_latch_reg <= manual_open_latch_next;
            open_fault_count_reg  <= open_fault_count_next;
            close_fault_count_reg <= close_fault_count_next;
            held_fault_reg        <= held_fault_next;
            held_drive_reg        <= held_drive_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (s_tready)
            m_tvalid_reg <= s_tvalid;
    end

    // The result register loads whenever a new tick is taken.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
            m_tdata_reg <= m_tdata_next;
    end

endmodule

`default_nettype wire

// ===== design/vmic_checker.sv =====
// Port-level checker for the valve mode and interlock controller, with its bind.
`default_nettype none
`include "assert_macros.svh"

module vmic_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              s_tvalid,
    input wire logic                              s_tready,
    input wire logic [vmic_pkg::IN_TDATA_W-1:0]   s_tdata,
    input wire logic                              m_tvalid,
    input wire logic                              m_tready,
    input wire logic [vmic_pkg::OUT_TDATA_W-1:0]  m_tdata
);

    logic in_xfer;
    logic oos_tick;
    logic drive_tick;
    logic stalled;
    logic oos_result_ok;
    logic fault_summary_ok;

    assign in_xfer    = s_tvalid && s_tready;
    assign oos_tick   = in_xfer && (s_tdata[1:0] == vmic_pkg::MODE_OUT_OF_SERVICE);
    assign drive_tick = in_xfer && ((s_tdata[1:0] == vmic_pkg::MODE_AUTOMATIC) ||
                                    (s_tdata[1:0] == vmic_pkg::MODE_MANUAL));
    assign stalled    = m_tvalid && !m_tready;

    // An out-of-service tick reports an empty status word and not in service.
    assign oos_result_ok    = m_tvalid && (m_tdata[7:0] == 8'h00) && !m_tdata[10];
    assign fault_summary_ok = m_tvalid && m_tdata[10] && (m_tdata[8] == (|m_tdata[7:4]));

    `VMIC_ASSERT(a_result_holds, stalled |=> m_tvalid && $stable(m_tdata), "result moved in stall")

    `VMIC_ASSERT(a_ready_when_empty, !m_tvalid |-> s_tready, "input stalled with empty output")

    `VMIC_ASSERT(a_oos_result, oos_tick |=> oos_result_ok, "out-of-service status not cleared")

    `VMIC_ASSERT(a_fault_summary, drive_tick |=> fault_summary_ok, "fault flag disagrees with status")

    // The reset is asynchronous, so once reset has been seen the output is empty.
    `VMIC_ASSERT_ALWAYS(a_no_result_in_reset, !rst_n |=> !m_tvalid, "result valid during reset")

endmodule

bind valve_mode_interlock_controller vmic_checker u_vmic_checker (.*);

`default_nettype wire

// ===== tb/sv/valve_mode_interlock_controller_tb.sv =====
// Self-checking testbench for the valve mode and interlock controller stream block.
`timescale 1ns / 100ps

module valve_mode_interlock_controller_tb;

    localparam int STALL_LIMIT   = 3000;
    localparam int PHASE_TICKS   = 115;
    localparam int HOLD_OFF_LEN  = 300;

    // Scan tick flags, in s_tdata order above op_mode.
    localparam logic [9:0] F_NONE      = 10'h000;
    localparam logic [9:0] F_OPEN_CMD  = 10'h001;
    localparam logic [9:0] F_CLOSE_CMD = 10'h002;
    localparam logic [9:0] F_RESET_CMD = 10'h004;
    localparam logic [9:0] F_OPEN_FB   = 10'h008;
    localparam logic [9:0] F_CLOSED_FB = 10'h010;
    localparam logic [9:0] F_ESTOP     = 10'h020;
    localparam logic [9:0] F_STOP      = 10'h040;
    localparam logic [9:0] F_ILK       = 10'h080;
    localparam logic [9:0] F_MUTEX     = 10'h100;
    localparam logic [9:0] F_AUTO      = 10'h200;
    localparam logic [9:0] F_ALL       = 10'h3FF;

    // Packed so that the struct is s_tdata[11:0] as it stands.
    typedef struct packed {
        logic            auto_req;
        logic            mutex_req;
        logic            ilk_req;
        logic            stop_req;
        logic            estop_in;
        logic            closed_fb;
        logic            open_fb;
        logic            rst_cmd;
        logic            close_cmd;
        logic            open_cmd;
        vmic_pkg::mode_t op_mode;
    } scan_tick_t;

    // Packed so that the struct is m_tdata[10:0] as it stands.
    typedef struct packed {
        logic       in_service;
        logic       drive;
        logic       fault;
        logic [7:0] word;
    } valve_status_t;

    typedef struct packed {
        logic        sim_on;
        logic        open_fb_used;
        logic        closed_fb_used;
        logic        ilk_used;
        logic        mtx_used;
        logic        ilk_opens;
        logic [15:0] open_ticks;
        logic [15:0] close_ticks;
    } valve_cfg_t;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [vmic_pkg::IN_TDATA_W-1:0]  s_tdata = '0;
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [vmic_pkg::OUT_TDATA_W-1:0] m_tdata;
    logic                             cfg_we = 1'b0;
    logic [vmic_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [vmic_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

    // Mirror of the controller state and configuration.
    valve_cfg_t  cfg = '0;
    logic        open_pos = 1'b0;
    logic        estop_flag = 1'b0;
    logic        ilk_flag = 1'b0;
    logic        man_open = 1'b0;
    logic [15:0] open_cnt = '0;
    logic [15:0] close_cnt = '0;
    logic        last_fault = 1'b0;
    logic        last_drive = 1'b0;

    valve_status_t pending_status[$];

    int mismatches = 0;
    int ticks_sent = 0;
    int results_seen = 0;
    int settings_used = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_off_left = 0;
    int quiet_cycles = 0;

    valve_mode_interlock_controller dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic scan_tick_t make_tick(vmic_pkg::mode_t m, logic [9:0] flags);
        return scan_tick_t'({flags, m});
    endfunction

    // On-delay: counts while the mismatch lasts, saturating at the tick count.
    function automatic logic fault_delay(input logic cond, inout logic [15:0] count,
                                         input logic [15:0] ticks);
        if (!cond)
        begin
            count = '0;
            return 1'b0;
        end
        if (count < ticks && count != 16'hFFFF)
            count = count + 16'd1;
        return count >= ticks;
    endfunction

    function automatic valve_status_t predict_scan(scan_tick_t t);
        valve_status_t r;
        logic ok_open, ok_close, mutex, of, cf, block;
        r = '0;
        if (t.op_mode == vmic_pkg::MODE_OUT_OF_SERVICE)
        begin
            open_pos = 1'b0;
            estop_flag = 1'b0;
            ilk_flag = 1'b0;
            r.fault = last_fault;
            r.drive = last_drive;
            r.in_service = 1'b0;
        end
        else if (t.op_mode == vmic_pkg::MODE_LOCAL)
        begin
            open_pos = t.open_fb;
            estop_flag = t.estop_in;
            ilk_flag = 1'b0;
            r.word = {estop_flag, 4'b0000, t.closed_fb, t.open_fb, open_pos};
            r.fault = last_fault;
            r.drive = last_drive;
            r.in_service = 1'b1;
        end
        else
        begin
            // Position check uses the open state from before this tick.
            if (cfg.sim_on || (!cfg.open_fb_used && !cfg.closed_fb_used))
            begin
                ok_open = open_pos;
                ok_close = !open_pos;
            end
            else if (cfg.open_fb_used && cfg.closed_fb_used)
            begin
                ok_open = open_pos && t.open_fb && !t.closed_fb;
                ok_close = !open_pos && !t.open_fb && t.closed_fb;
            end
            else if (cfg.open_fb_used)
            begin
                ok_open = open_pos && t.open_fb;
                ok_close = !open_pos && !t.open_fb;
            end
            else
            begin
                ok_open = open_pos && !t.closed_fb;
                ok_close = !open_pos && t.closed_fb;
            end

            if (t.estop_in || t.stop_req)
                estop_flag = 1'b1;
            else if (t.rst_cmd)
                estop_flag = 1'b0;

            if (!cfg.ilk_used)
                ilk_flag = 1'b0;
            else if (t.ilk_req)
                ilk_flag = 1'b1;
            else if (t.rst_cmd)
                ilk_flag = 1'b0;

            mutex = t.mutex_req && cfg.mtx_used;
            of = fault_delay(open_pos && !ok_open, open_cnt, cfg.open_ticks);
            cf = fault_delay(!open_pos && !ok_close, close_cnt, cfg.close_ticks);

            if (t.op_mode == vmic_pkg::MODE_AUTOMATIC)
            begin
                if (cfg.ilk_opens)
                    open_pos = ilk_flag || (t.auto_req && !estop_flag && !mutex);
                else
                    open_pos = t.auto_req && !estop_flag && !ilk_flag && !mutex;
            end
            else
            begin
                block = estop_flag || mutex || (!cfg.ilk_opens && ilk_flag);
                if (t.open_cmd && !block)
                    man_open = 1'b1;
                if (t.close_cmd || block)
                    man_open = 1'b0;
                open_pos = man_open || (cfg.ilk_opens && ilk_flag);
            end

            r.word = {estop_flag, ilk_flag, cf, of, mutex, t.closed_fb, t.open_fb,
                      open_pos};
            last_fault = |(r.word & vmic_pkg::FAULT_MASK[7:0]);
            last_drive = cfg.sim_on ? 1'b0 : open_pos;
            r.fault = last_fault;
            r.drive = last_drive;
            r.in_service = 1'b1;
        end
        return r;
    endfunction

    // Mostly auto and manual ticks with feedback that agrees with the valve,
    // so that the fault delays run out only now and then.
    function automatic scan_tick_t random_tick();
        scan_tick_t t;
        int sel;
        sel = $urandom_range(99);
        if (sel < 8)
            t.op_mode = vmic_pkg::MODE_OUT_OF_SERVICE;
        else if (sel < 16)
            t.op_mode = vmic_pkg::MODE_LOCAL;
        else if (sel < 58)
            t.op_mode = vmic_pkg::MODE_AUTOMATIC;
        else
            t.op_mode = vmic_pkg::MODE_MANUAL;
        t.open_cmd  = ($urandom_range(99) < 30);
        t.close_cmd = ($urandom_range(99) < 15);
        t.rst_cmd   = ($urandom_range(99) < 25);
        t.estop_in  = ($urandom_range(99) < 6);
        t.stop_req  = ($urandom_range(99) < 6);
        t.ilk_req   = ($urandom_range(99) < 20);
        t.mutex_req = ($urandom_range(99) < 20);
        t.auto_req  = ($urandom_range(99) < 65);
        if ($urandom_range(99) < 75)
        begin
            t.open_fb = open_pos;
            t.closed_fb = !open_pos;
        end
        else
        begin
            t.open_fb = 1'($urandom_range(1));
            t.closed_fb = 1'($urandom_range(1));
        end
        return t;
    endfunction

    function automatic valve_cfg_t random_cfg();
        valve_cfg_t c;
        c.sim_on         = ($urandom_range(99) < 25);
        c.open_fb_used   = 1'($urandom_range(1));
        c.closed_fb_used = 1'($urandom_range(1));
        c.ilk_used       = 1'($urandom_range(1));
        c.mtx_used       = 1'($urandom_range(1));
        c.ilk_opens      = 1'($urandom_range(1));
        c.open_ticks     = 16'(($urandom_range(99) < 85) ? $urandom_range(6) :
                                                            $urandom_range(65535));
        c.close_ticks    = 16'(($urandom_range(99) < 85) ? $urandom_range(6) :
                                                            $urandom_range(65535));
        return c;
    endfunction

    // The write itself lands on the rising edge after this falling edge.
    task automatic write_reg(vmic_pkg::reg_index_t idx,
                             logic [vmic_pkg::CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            vmic_pkg::REG_SIMULATION_ON:         cfg.sim_on = val[0];
            vmic_pkg::REG_OPEN_CONTACT_USED:     cfg.open_fb_used = val[0];
            vmic_pkg::REG_CLOSED_CONTACT_USED:   cfg.closed_fb_used = val[0];
            vmic_pkg::REG_INTERLOCK_USED:        cfg.ilk_used = val[0];
            vmic_pkg::REG_MUTEX_USED:            cfg.mtx_used = val[0];
            vmic_pkg::REG_INTERLOCK_FORCES_OPEN: cfg.ilk_opens = val[0];
            vmic_pkg::REG_OPEN_FAULT_TICKS:      cfg.open_ticks = val;
            vmic_pkg::REG_CLOSE_FAULT_TICKS:     cfg.close_ticks = val;
            default: ;
        endcase
    endtask

    task automatic apply_config(valve_cfg_t c);
        write_reg(vmic_pkg::REG_SIMULATION_ON, {15'd0, c.sim_on});
        write_reg(vmic_pkg::REG_OPEN_CONTACT_USED, {15'd0, c.open_fb_used});
        write_reg(vmic_pkg::REG_CLOSED_CONTACT_USED, {15'd0, c.closed_fb_used});
        write_reg(vmic_pkg::REG_INTERLOCK_USED, {15'd0, c.ilk_used});
        write_reg(vmic_pkg::REG_MUTEX_USED, {15'd0, c.mtx_used});
        write_reg(vmic_pkg::REG_INTERLOCK_FORCES_OPEN, {15'd0, c.ilk_opens});
        write_reg(vmic_pkg::REG_OPEN_FAULT_TICKS, c.open_ticks);
        write_reg(vmic_pkg::REG_CLOSE_FAULT_TICKS, c.close_ticks);
        @(negedge clk);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    task automatic send_tick(scan_tick_t t);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {{(vmic_pkg::IN_TDATA_W-12){1'b0}}, t};
        do
            @(posedge clk);
        while (!s_tready);
        pending_status.push_back(predict_scan(t));
        ticks_sent++;
    endtask

    // Sender goes quiet until every predicted status has come back.
    task automatic drain_results();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_status.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic compare_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    task automatic test_mode_paths();
        valve_cfg_t c;
        c = '{sim_on: 1'b0, open_fb_used: 1'b1, closed_fb_used: 1'b1, ilk_used: 1'b1,
              mtx_used: 1'b1, ilk_opens: 1'b0, open_ticks: 16'd2, close_ticks: 16'd0};
        apply_config(c);
        send_tick(make_tick(vmic_pkg::MODE_OUT_OF_SERVICE, F_ALL));
        send_tick(make_tick(vmic_pkg::MODE_OUT_OF_SERVICE, F_NONE));
        send_tick(make_tick(vmic_pkg::MODE_LOCAL, F_OPEN_FB | F_CLOSED_FB | F_ESTOP));
        send_tick(make_tick(vmic_pkg::MODE_LOCAL, F_NONE));
    endtask

    // Open fault delay, mutex, emergency stop and interlock latches in automatic mode.
    task automatic test_auto_gating();
        send_tick(make_tick(vmic_pkg::MODE_AUTOMATIC, F_AUTO | F_CLOSED_FB));
        send_tick(make_tick(vmic_pkg::MODE_AUTOMATIC, F_AUTO | F_CLOSED_FB));
        send_tick(make_tick(vmic_pkg::MODE_AUTOMATIC, F_AUTO | F_CLOSED_FB));
        send_tick(make_tick(vmic_pkg::MODE_AUTOMATIC, F_AUTO | F_OPEN_FB));
        send_tick(make_tick(vmic_pkg::MODE_AUTOMATIC, F_AUTO | F_OPEN_FB | F_MUTEX));
        send_tick(make_tick(vmic_pkg::MODE_AUTOMATIC, F_AUTO | F_ESTOP));
        // Reset while the stop request is still present must leave the latch set.
        send_tick(make_tick(vmic_pkg::MODE_AUTOMATIC,
                            F_AUTO | F_RESET_CMD | F_STOP | F_CLOSED_FB));
        send_tick(make_tick(vmic_pkg::MODE_AUTOMATIC, F_RESET_CMD | F_CLOSED_FB));
        send_tick(make_tick(vmic_pkg::MODE_AUTOMATIC, F_AUTO | F_ILK | F_CLOSED_FB));
        send_tick(make_tick(vmic_pkg::MODE_AUTOMATIC, F_RESET_CMD | F_CLOSED_FB));
    endtask

    task automatic test_manual_latch();
        send_tick(make_tick(vmic_pkg::MODE_MANUAL, F_OPEN_CMD | F_CLOSED_FB));
        send_tick(make_tick(vmic_pkg::MODE_MANUAL, F_OPEN_CMD | F_CLOSE_CMD | F_OPEN_FB));
        send_tick(make_tick(vmic_pkg::MODE_MANUAL, F_OPEN_CMD | F_ILK | F_CLOSED_FB));
        send_tick(make_tick(vmic_pkg::MODE_MANUAL, F_ALL));
    endtask

    task automatic test_interlock_opens();
        valve_cfg_t c;
        c = '{sim_on: 1'b1, open_fb_used: 1'b1, closed_fb_used: 1'b1, ilk_used: 1'b1,
              mtx_used: 1'b1, ilk_opens: 1'b1, open_ticks: 16'hFFFF,
              close_ticks: 16'hFFFF};
        drain_results();
        apply_config(c);
        send_tick(make_tick(vmic_pkg::MODE_AUTOMATIC, F_ILK | F_CLOSED_FB));
        send_tick(make_tick(vmic_pkg::MODE_MANUAL, F_RESET_CMD | F_OPEN_FB));
        send_tick(make_tick(vmic_pkg::MODE_MANUAL, F_ILK | F_MUTEX | F_OPEN_FB));
        send_tick(make_tick(vmic_pkg::MODE_LOCAL, F_ALL));
        send_tick(make_tick(vmic_pkg::MODE_OUT_OF_SERVICE, F_ALL));
    endtask

    task automatic test_random_phases();
        valve_cfg_t c;
        for (int regime = 0; regime < 3; regime++)
        begin
            send_idle_pct = (regime == 0) ? 27 : (regime == 1) ? 69 : 0;
            recv_idle_pct = (regime == 0) ? 69 : (regime == 1) ? 27 : 0;
            for (int setting = 0; setting < 4; setting++)
            begin
                if (regime == 0 && setting == 0)
                    c = '0;
                else if (regime == 0 && setting == 1)
                    c = '{sim_on: 1'b1, open_fb_used: 1'b1, closed_fb_used: 1'b1,
                          ilk_used: 1'b1, mtx_used: 1'b1, ilk_opens: 1'b1,
                          open_ticks: 16'hFFFF, close_ticks: 16'hFFFF};
                else
                    c = random_cfg();
                drain_results();
                apply_config(c);
                for (int n = 0; n < PHASE_TICKS; n++)
                begin
                    send_tick(random_tick());
                    if ($urandom_range(149) == 0)
                        drain_results();
                end
            end
        end
    endtask

    // Receiver holds off long enough for the block to stall its input.
    task automatic test_backpressure();
        drain_results();
        apply_config(random_cfg());
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_off_left = HOLD_OFF_LEN;
        for (int n = 0; n < 40; n++)
            send_tick(random_tick());
        drain_results();
    endtask

    always @(negedge clk)
    begin
        if (hold_off_left > 0)
        begin
            m_tready <= 1'b0;
            hold_off_left = hold_off_left - 1;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        valve_status_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            if (pending_status.size() == 0)
            begin
                $error("status transfer with nothing predicted: m_tdata 0x%0h", m_tdata);
                mismatches++;
            end
            else
            begin
                want = pending_status.pop_front();
                compare_field("status_word", 32'(want.word), 32'(m_tdata[7:0]));
                compare_field("fault_flag", 32'(want.fault), 32'(m_tdata[8]));
                compare_field("valve_drive", 32'(want.drive), 32'(m_tdata[9]));
                compare_field("in_service", 32'(want.in_service), 32'(m_tdata[10]));
                compare_field("padding", 0, 32'(m_tdata[vmic_pkg::OUT_TDATA_W-1:11]));
            end
        end
    end

    // Watchdog: ends the run when no transfer happens on either side for too long.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Timeout after %0d cycles without a transfer", quiet_cycles);
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_mode_paths();
        test_auto_gating();
        test_manual_latch();
        test_interlock_opens();
        test_random_phases();
        test_backpressure();
        drain_results();
        $display("Checked %0d status results for %0d scan ticks over %0d register settings,",
                 results_seen, ticks_sent, settings_used);
        $display("with all modes, sender and receiver stalls and a long output hold-off.");
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+design
design/vmic_pkg.sv
design/valve_mode_interlock_controller.sv
design/vmic_checker.sv
tb/sv/valve_mode_interlock_controller_tb.sv
